// ===== sv/tbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_pkg
// Shared constants and types for the triangular Bezier point evaluator.
// ----------------------------------------------------------------------------
package tbe_pkg;

  localparam int MaxDegreeDef   = 8;
  localparam int CoordCountDef  = 4;
  localparam int CoordWidthDef  = 32;
  localparam int MaxSubdivDef   = 8;
  localparam int FracBits       = 16;
  localparam int OutWidth       = 32;
  localparam int UvWidth        = 9;
  localparam int IdxWidth       = 6;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  localparam logic [3:0] RegDegree = 4'd0;
  localparam logic [3:0] RegDepth  = 4'd1;

  // Command from the sequencer to every lane.
  typedef struct packed {
    logic cp_rd;     // read one control entry into the copy register
    logic wk_wr;     // write one scratch entry
    logic wk_blend;  // the scratch write takes the blend result, else the copy register
    logic rd;        // read two scratch entries and shift the operand window
  } lane_cmd_t;

endpackage

// ===== sv/triangular_bezier_point_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangular_bezier_point_eval
// De Casteljau evaluation of a triangular Bezier patch, one lane per coordinate.
// ----------------------------------------------------------------------------
// A load item gives no result; loads can follow back to back.
// An evaluate item copies the (n+1)(n+2)/2 control points into scratch, then runs
// n(n+1)(n+2)/6 blends with a prime fetch at each of the n(n+1)/2 row starts, using
// two registered scratch reads per cycle and lane, and then raises out_valid_o.
// An out-of-range grid point skips the copy and the blends and raises out_valid_o.
// One item is in work at a time. Reset clears the sequencer and the registers
// (degree 3, depth 4); the control store is undefined until written.
module triangular_bezier_point_eval #(
  parameter int MAX_DEGREE       = tbe_pkg::MaxDegreeDef,
  parameter int COORD_COUNT      = tbe_pkg::CoordCountDef,
  parameter int COORD_WIDTH      = tbe_pkg::CoordWidthDef,
  parameter int MAX_SUBDIV_DEPTH = tbe_pkg::MaxSubdivDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [5:0]  point_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] coord_w_i,
  input  logic [8:0]  grid_u_i,
  input  logic [8:0]  grid_v_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_w_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int PtCount = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
  localparam int AW = (PtCount > 64) ? $clog2(PtCount) : 6;
  localparam int FB = tbe_pkg::FracBits;
  localparam int DegW = $clog2(MAX_DEGREE + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCopy  = 2'd1;
  localparam logic [1:0] StBlend = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [3:0] degree_q, depth_q;
  logic [1:0] state_q, state_d;
  logic [AW-1:0] cnt_q;       // point count of the net
  logic [AW-1:0] copy_q;      // copy address
  logic [DegW-1:0] n_q, lvl_q, k_q, j_q;
  logic [AW-1:0] r0_q, r1_q;  // start of row k and row k+1
  logic [FB:0] wu_q, wv_q, ww_q;
  logic stat_q, out_valid_q, res_ok_q;
  // At the start of each row a prime cycle only fetches the first point of the row.
  logic prime_q;
  // Scratch writes land in the cycle after the read that feeds them.
  logic cp_wr_q, bl_wr_q;
  logic [AW-1:0] cp_wa_q, bl_wa_q;

  // Clamped configuration and the grid bound check of the incoming item.
  logic [DegW-1:0] n_c;
  logic [3:0] dep_c;
  logic [12:0] uv_sum;
  logic [12:0] pts;
  logic outside;

  always_comb begin
    if (degree_q == 4'd0) n_c = DegW'(1);
    else if (32'(degree_q) > MAX_DEGREE) n_c = DegW'(MAX_DEGREE);
    else n_c = DegW'(degree_q);
    dep_c = (32'(depth_q) > MAX_SUBDIV_DEPTH) ? 4'(MAX_SUBDIV_DEPTH) : depth_q;
  end
  assign pts = 13'd1 << dep_c;
  assign uv_sum = 13'(grid_u_i) + 13'(grid_v_i);
  assign outside = uv_sum > pts;

  logic in_acc, busy;
  assign busy = (state_q != StIdle) || out_valid_q;
  assign in_stall_o = busy;
  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 4'd3;
      depth_q  <= 4'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tbe_pkg::RegDegree) degree_q <= cfg_data_i;
      else if (cfg_index_i == tbe_pkg::RegDepth) depth_q <= cfg_data_i;
    end
  end

  // Blend sequencing: level d from n-1 down to 0, rows k <= d, entries j+k <= d.
  logic blend_last_row, blend_last_j, blend_last;
  assign blend_last_j   = (32'(j_q) + 32'(k_q)) == 32'(lvl_q);
  assign blend_last_row = k_q == lvl_q;
  assign blend_last     = blend_last_j && blend_last_row && lvl_q == '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc && opcode_i == tbe_pkg::OpEval) state_d = outside ? StDone : StCopy;
      StCopy:  if (copy_q == cnt_q - AW'(1)) state_d = StBlend;
      StBlend: if (!prime_q && blend_last) state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      stat_q <= 1'b0;
      res_ok_q <= 1'b0;
      copy_q <= '0;
      cnt_q <= '0;
      n_q <= '0; lvl_q <= '0; k_q <= '0; j_q <= '0;
      r0_q <= '0; r1_q <= '0;
      prime_q <= 1'b0;
      cp_wr_q <= 1'b0; bl_wr_q <= 1'b0;
      cp_wa_q <= '0; bl_wa_q <= '0;
    end else begin
      state_q <= state_d;
      cp_wr_q <= state_q == StCopy;
      cp_wa_q <= copy_q;
      bl_wr_q <= state_q == StBlend && !prime_q;
      bl_wa_q <= r0_q + AW'(j_q);
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_acc && opcode_i == tbe_pkg::OpEval) begin
          n_q <= n_c;
          lvl_q <= n_c - DegW'(1);
          k_q <= '0; j_q <= '0;
          r0_q <= '0;
          r1_q <= AW'(n_c) + AW'(1);
          copy_q <= '0;
          cnt_q <= AW'((32'(n_c) + 1) * (32'(n_c) + 2) / 2);
          stat_q <= outside;
          res_ok_q <= !outside;
          prime_q <= 1'b1;
        end
        StCopy: copy_q <= copy_q + AW'(1);
        StBlend: begin
          if (prime_q) begin
            prime_q <= 1'b0;
          end else if (!blend_last_j) begin
            j_q <= j_q + DegW'(1);
          end else if (!blend_last_row) begin
            j_q <= '0;
            k_q <= k_q + DegW'(1);
            r0_q <= r1_q;
            r1_q <= r1_q + AW'(n_q) - AW'(k_q);
            prime_q <= 1'b1;
          end else begin
            j_q <= '0; k_q <= '0;
            lvl_q <= lvl_q - DegW'(1);
            r0_q <= '0;
            r1_q <= AW'(n_q) + AW'(1);
            prime_q <= 1'b1;
          end
        end
        StDone: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == tbe_pkg::OpEval) begin
      wu_q <= (FB+1)'({8'd0, grid_u_i} << (FB - 32'(dep_c)));
      wv_q <= (FB+1)'({8'd0, grid_v_i} << (FB - 32'(dep_c)));
      ww_q <= (FB+1)'((17'd1 << FB) - ({8'd0, grid_u_i} << (FB - 32'(dep_c)))
                                   - ({8'd0, grid_v_i} << (FB - 32'(dep_c))));
    end
  end

  // A prime cycle fetches the first point of the row; a blend cycle fetches the
  // next point of the row and the point below, and the blend is written in the next cycle.
  tbe_pkg::lane_cmd_t cmd;
  logic [AW-1:0] a_b, a_c, a_w;
  assign cmd.cp_rd    = state_q == StCopy;
  assign cmd.rd       = state_q == StBlend;
  assign cmd.wk_wr    = cp_wr_q || bl_wr_q;
  assign cmd.wk_blend = bl_wr_q;
  assign a_b = prime_q ? r0_q : r0_q + AW'(j_q) + AW'(1);
  assign a_c = r1_q + AW'(j_q);
  assign a_w = bl_wr_q ? bl_wa_q : cp_wa_q;

  logic wr_en;
  assign wr_en = in_acc && opcode_i == tbe_pkg::OpLoad && 32'(point_index_i) < PtCount;

  logic signed [31:0] lane_in [4];
  logic signed [31:0] lane_out [4];
  assign lane_in[0] = coord_x_i;
  assign lane_in[1] = coord_y_i;
  assign lane_in[2] = coord_z_i;
  assign lane_in[3] = coord_w_i;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    if (g < COORD_COUNT) begin : g_on
      logic [COORD_WIDTH-1:0] root;
      tbe_lane #(.CoordWidth(COORD_WIDTH), .PtCount(PtCount), .AddrWidth(AW)) u_lane (
        .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_addr_i(AW'(point_index_i)),
        .wr_data_i(lane_in[g]), .cmd_i(cmd), .cp_addr_i(copy_q), .addr_b_i(a_b),
        .addr_c_i(a_c), .addr_wr_i(a_w), .wu_i(wu_q), .wv_i(wv_q), .ww_i(ww_q),
        .root_o(root));
      tbe_merge #(.CoordWidth(COORD_WIDTH)) u_merge (
        .root_i(root), .valid_i(res_ok_q), .out_o(lane_out[g]));
    end else begin : g_off
      assign lane_out[g] = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o = lane_out[0];
  assign out_y_o = lane_out[1];
  assign out_z_o = lane_out[2];
  assign out_w_o = lane_out[3];
  assign status_o = stat_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> out_valid_q) else $error("result lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(status_o))
    else $error("result dropped");
`endif

endmodule

// ===== sv/tbe_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_lane
// One coordinate lane: control store, scratch store and a blend unit.
// ----------------------------------------------------------------------------
module tbe_lane #(
  parameter int CoordWidth = 32,
  parameter int PtCount    = 45,
  parameter int AddrWidth  = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [AddrWidth-1:0]    wr_addr_i,
  input  logic signed [31:0]      wr_data_i,
  input  tbe_pkg::lane_cmd_t      cmd_i,
  input  logic [AddrWidth-1:0]    cp_addr_i,
  input  logic [AddrWidth-1:0]    addr_b_i,
  input  logic [AddrWidth-1:0]    addr_c_i,
  input  logic [AddrWidth-1:0]    addr_wr_i,
  input  logic [tbe_pkg::FracBits:0] wu_i,
  input  logic [tbe_pkg::FracBits:0] wv_i,
  input  logic [tbe_pkg::FracBits:0] ww_i,
  output logic [CoordWidth-1:0]   root_o
);

  localparam int FB = tbe_pkg::FracBits;
  localparam int SumW = CoordWidth + FB + 3;
  localparam logic [CoordWidth-1:0] Bias = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam logic signed [31:0] CMaxS =
    (CoordWidth >= 32) ? 32'sh7fffffff : 32'((64'sd1 <<< (CoordWidth-1)) - 1);
  localparam logic signed [31:0] CMinS = -CMaxS - 32'sd1;

  logic [CoordWidth-1:0] ctrl_mem [PtCount];
  logic [CoordWidth-1:0] work_mem [PtCount];
  logic [CoordWidth-1:0] root_q;
  logic [CoordWidth-1:0] cp_q;
  logic [CoordWidth-1:0] ra_q, rb_q, rc_q;
  logic signed [31:0]    clamped;
  logic [SumW-1:0]       sum;
  logic [SumW-FB-1:0]    rnd;
  logic [CoordWidth-1:0] blended;

  always_comb begin
    if (wr_data_i > CMaxS) clamped = CMaxS;
    else if (wr_data_i < CMinS) clamped = CMinS;
    else clamped = wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ctrl_mem[wr_addr_i] <= CoordWidth'(clamped) ^ Bias;
    end
    if (cmd_i.cp_rd) begin
      cp_q <= ctrl_mem[cp_addr_i];
    end
  end

  // The operand window slides along a row: the second operand of one blend is
  // the first operand of the next, so two reads a cycle are enough.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wk_wr) begin
      work_mem[addr_wr_i] <= cmd_i.wk_blend ? blended : cp_q;
    end
    if (cmd_i.rd) begin
      ra_q <= rb_q;
      rb_q <= work_mem[addr_b_i];
      rc_q <= work_mem[addr_c_i];
    end
  end

  // Weights sum to one, so one blend is a weighted mean of three points.
  assign sum = SumW'(wu_i) * SumW'(ra_q)
             + SumW'(wv_i) * SumW'(rb_q)
             + SumW'(ww_i) * SumW'(rc_q)
             + SumW'(1 << (FB - 1));
  assign rnd = sum[SumW-1:FB];
  assign blended = (rnd > (SumW-FB)'({CoordWidth{1'b1}})) ? {CoordWidth{1'b1}}
                 : rnd[CoordWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cmd_i.wk_wr && cmd_i.wk_blend && addr_wr_i == '0) begin
      root_q <= blended;
    end
  end

  assign root_o = root_q;

endmodule

// ===== sv/tbe_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_merge
// Removes the bias from each lane result and saturates to signed Q16.16; zero when not valid.
// ----------------------------------------------------------------------------
module tbe_merge #(
  parameter int CoordWidth = 32
) (
  input  logic [CoordWidth-1:0]        root_i,
  input  logic                         valid_i,
  output logic signed [tbe_pkg::OutWidth-1:0] out_o
);

  localparam logic [CoordWidth-1:0] Bias = {1'b1, {(CoordWidth-1){1'b0}}};
  logic signed [CoordWidth:0] unb;

  assign unb = $signed({1'b0, root_i}) - $signed({1'b0, Bias});

  always_comb begin
    if (!valid_i) out_o = '0;
    else if (unb > (CoordWidth+1)'(64'sh7fffffff) && CoordWidth > 32) out_o = 32'sh7fffffff;
    else if (unb < -(CoordWidth+1)'(64'sh80000000) && CoordWidth > 32) out_o = 32'sh80000000;
    else out_o = 32'(unb);
  end

endmodule
